[design/opmr_pkg.sv]
// ---------------------------------------------------------------------------
// opmr_pkg
// Shared widths, codes, weight tables and microcode types for the odd-parity
// monomial ranker.
// ---------------------------------------------------------------------------
`default_nettype none

package opmr_pkg;

  // field widths
  localparam int unsigned ExpW     = 6;
  localparam int unsigned IdxW     = 7;
  localparam int unsigned SumW     = 9;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned PlaceW   = 23;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned TabDepth = 64;

  // default degree limit
  localparam int unsigned MaxDegreeDef = 63;

  // status codes
  typedef enum logic [StatusW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_SUM    = 2'd1,
    STATUS_PARITY = 2'd2,
    STATUS_DEGREE = 2'd3
  } status_e;

  // weight tables psi3(j) = C(j+2,2) and psi4(j) = C(j+3,3)
  typedef logic [WeightW-1:0] weight_tab_t [TabDepth];

  function automatic weight_tab_t build_w3();
    weight_tab_t t;
    for (int unsigned j = 0; j < TabDepth; j++) begin
      t[j] = WeightW'((j + 1) * (j + 2) / 2);
    end
    return t;
  endfunction

  function automatic weight_tab_t build_w4();
    weight_tab_t t;
    for (int unsigned j = 0; j < TabDepth; j++) begin
      t[j] = WeightW'((j + 1) * (j + 2) * (j + 3) / 6);
    end
    return t;
  endfunction

  localparam weight_tab_t W3Tab = build_w3();
  localparam weight_tab_t W4Tab = build_w4();

  // microcode program
  localparam int unsigned NumSteps = 10;
  localparam int unsigned StepW    = 4;
  typedef logic [StepW-1:0] step_t;

  localparam step_t StepCheck  = 4'd0;
  localparam step_t StepE5     = 4'd1;
  localparam step_t StepOdd    = 4'd2;
  localparam step_t StepW3Init = 4'd3;
  localparam step_t StepW3     = 4'd4;
  localparam step_t StepW2Init = 4'd5;
  localparam step_t StepW2     = 4'd6;
  localparam step_t StepE1     = 4'd7;
  localparam step_t StepWait   = 4'd8;
  localparam step_t StepFinish = 4'd9;

  // jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_ERROR     = 3'd1,
    COND_IDX_LT_M  = 3'd2,
    COND_IDX_LE_N4 = 3'd3,
    COND_IDX_LE_N3 = 3'd4,
    COND_OUT_BUSY  = 3'd5
  } cond_e;

  // multiplier operand a
  typedef enum logic [1:0] {
    A_ONE    = 2'd0,
    A_E5     = 2'd1,
    A_IDX_P1 = 2'd2
  } sel_a_e;

  // multiplier operand b
  typedef enum logic [2:0] {
    B_W4_N4  = 3'd0,
    B_W4_D_I = 3'd1,
    B_W3_I   = 3'd2,
    B_IDX_P1 = 3'd3,
    B_E1     = 3'd4
  } sel_b_e;

  // loop index update
  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_ONE  = 3'd1,
    IDX_N3P1 = 3'd2,
    IDX_N2P1 = 3'd3,
    IDX_INC1 = 3'd4,
    IDX_INC2 = 3'd5
  } idx_op_e;

  // one control word of the program
  typedef struct packed {
    cond_e   cond;
    step_t   jump;
    logic    acc_en;
    sel_a_e  sel_a;
    sel_b_e  sel_b;
    idx_op_e idx_op;
    logic    out_ld;
    logic    done;
  } ucode_t;

  // condition flags from the datapath
  typedef struct packed {
    logic err;
    logic idx_lt_m;
    logic idx_le_n4;
    logic idx_le_n3;
    logic out_busy;
  } flags_t;

  // gated actions to the datapath
  typedef struct packed {
    logic    acc_en;
    sel_a_e  sel_a;
    sel_b_e  sel_b;
    idx_op_e idx_op;
    logic    out_ld;
  } action_t;

endpackage

`default_nettype wire

[design/opmr_in_if.sv]
// ---------------------------------------------------------------------------
// opmr_in_if
// Input channel: one exponent vector and its claimed degree per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface opmr_in_if;
  import opmr_pkg::*;

  logic            valid;
  logic            ready;
  logic [ExpW-1:0] exponent_0;
  logic [ExpW-1:0] exponent_1;
  logic [ExpW-1:0] exponent_2;
  logic [ExpW-1:0] exponent_3;
  logic [ExpW-1:0] exponent_4;
  logic [ExpW-1:0] exponent_5;
  logic [ExpW-1:0] degree;

  modport source (
    output valid, exponent_0, exponent_1, exponent_2, exponent_3,
           exponent_4, exponent_5, degree,
    input  ready
  );

  modport sink (
    input  valid, exponent_0, exponent_1, exponent_2, exponent_3,
           exponent_4, exponent_5, degree,
    output ready
  );
endinterface

`default_nettype wire

[design/opmr_out_if.sv]
// ---------------------------------------------------------------------------
// opmr_out_if
// Output channel: one rank and status per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface opmr_out_if;
  import opmr_pkg::*;

  logic               valid;
  logic               ready;
  logic [PlaceW-1:0]  place;
  logic [StatusW-1:0] status;

  modport source (
    output valid, place, status,
    input  ready
  );

  modport sink (
    input  valid, place, status,
    output ready
  );
endinterface

`default_nettype wire

[design/opmr_seq.sv]
// ---------------------------------------------------------------------------
// opmr_seq
// Microcode sequencer: step counter, program rom and conditional jumps.
// ---------------------------------------------------------------------------
`default_nettype none

module opmr_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  opmr_pkg::flags_t  flags_i,
  output opmr_pkg::action_t act_o,
  output logic              busy_o
);
  import opmr_pkg::*;

  // program: cond, jump, acc_en, sel_a, sel_b, idx_op, out_ld, done
  localparam ucode_t Ucode [NumSteps] = '{
    '{COND_ERROR,     StepWait,  1'b0, A_ONE,    B_E1,     IDX_HOLD, 1'b0, 1'b0},
    '{COND_ALWAYS,    StepCheck, 1'b1, A_E5,     B_W4_N4,  IDX_ONE,  1'b0, 1'b0},
    '{COND_IDX_LT_M,  StepOdd,   1'b1, A_IDX_P1, B_W4_D_I, IDX_INC2, 1'b0, 1'b0},
    '{COND_ALWAYS,    StepCheck, 1'b0, A_ONE,    B_E1,     IDX_N3P1, 1'b0, 1'b0},
    '{COND_IDX_LE_N4, StepW3,    1'b1, A_ONE,    B_W3_I,   IDX_INC1, 1'b0, 1'b0},
    '{COND_ALWAYS,    StepCheck, 1'b0, A_ONE,    B_E1,     IDX_N2P1, 1'b0, 1'b0},
    '{COND_IDX_LE_N3, StepW2,    1'b1, A_ONE,    B_IDX_P1, IDX_INC1, 1'b0, 1'b0},
    '{COND_ALWAYS,    StepCheck, 1'b1, A_ONE,    B_E1,     IDX_HOLD, 1'b0, 1'b0},
    '{COND_OUT_BUSY,  StepWait,  1'b0, A_ONE,    B_E1,     IDX_HOLD, 1'b0, 1'b0},
    '{COND_ALWAYS,    StepCheck, 1'b0, A_ONE,    B_E1,     IDX_HOLD, 1'b1, 1'b1}
  };

  step_t  pc_q, pc_d;
  logic   busy_q, busy_d;
  ucode_t word;
  logic   cond_true;
  logic   taken;
  logic   exec;

  assign word = Ucode[pc_q];

  // condition select
  always_comb begin
    unique case (word.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_ERROR:     cond_true = flags_i.err;
      COND_IDX_LT_M:  cond_true = flags_i.idx_lt_m;
      COND_IDX_LE_N4: cond_true = flags_i.idx_le_n4;
      COND_IDX_LE_N3: cond_true = flags_i.idx_le_n3;
      COND_OUT_BUSY:  cond_true = flags_i.out_busy;
      default:        cond_true = 1'b0;
    endcase
  end

  // loop bodies run only while their condition holds
  assign taken = (word.cond != COND_ALWAYS) && cond_true;
  assign exec  = busy_q && cond_true;

  // gated actions
  always_comb begin
    act_o.acc_en = exec & word.acc_en;
    act_o.sel_a  = word.sel_a;
    act_o.sel_b  = word.sel_b;
    act_o.idx_op = exec ? word.idx_op : IDX_HOLD;
    act_o.out_ld = exec & word.out_ld;
  end

  // step counter
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (start_i) begin
      pc_d   = StepCheck;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (exec && word.done) begin
        pc_d   = StepCheck;
        busy_d = 1'b0;
      end else if (taken) begin
        pc_d = word.jump;
      end else begin
        pc_d = pc_q + step_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= StepCheck;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

[design/odd_parity_monomial_rank_top.sv]
// ---------------------------------------------------------------------------
// odd_parity_monomial_rank_top
// Ranks a six-variable monomial among those of its degree with odd e4+e5.
// ---------------------------------------------------------------------------
//
// channel  direction  handshake        payload
// in_i     input      valid / ready    exponent_0..exponent_5, degree
// out_o    output     valid / ready    place, status
// cfg      input      cfg_we_i         cfg_wdata_i (max_degree)
//
// one word at a time; the shared multiply-add steps through the program loops
// for each word. a flagged word skips the loops and goes from the check step
// straight to the wait step. reset clears the sequencer, the output valid
// and sets max_degree to 63. a stalled output holds the sequencer in its wait
// step; a new word is taken as soon as the previous one sits in the output.
// ---------------------------------------------------------------------------
`default_nettype none

module odd_parity_monomial_rank_top #(
  parameter int unsigned MAX_DEGREE = opmr_pkg::MaxDegreeDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  opmr_in_if.sink                   in_i,
  opmr_out_if.source                out_o,
  input  logic                      cfg_we_i,
  input  logic [opmr_pkg::ExpW-1:0] cfg_wdata_i
);
  import opmr_pkg::*;

  logic [ExpW-1:0]    max_degree_q;
  logic [ExpW-1:0]    e0_q, e1_q, e2_q, e3_q, e4_q, e5_q, deg_q;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [PlaceW-1:0]  acc_q, acc_d;
  logic               out_valid_q;
  logic [PlaceW-1:0]  place_q;
  logic [StatusW-1:0] status_q;

  logic               start;
  logic               busy;
  flags_t             flags;
  action_t            act;

  logic [SumW-1:0]    sum;
  logic [IdxW-1:0]    m;
  logic [ExpW-1:0]    lim;
  logic [ExpW-1:0]    n4, n3, n2;
  logic [IdxW-1:0]    idx_p1;
  logic [ExpW-1:0]    d_minus_i;
  status_e            status_w;
  logic [IdxW-1:0]    mul_a;
  logic [WeightW-1:0] mul_b;
  logic [PlaceW-1:0]  prod;

  // sequencer
  assign start      = in_i.valid && in_i.ready;
  assign in_i.ready = !busy;

  opmr_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .act_o   (act),
    .busy_o  (busy)
  );

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_degree_q <= ExpW'(MaxDegreeDef);
    end else if (cfg_we_i) begin
      max_degree_q <= cfg_wdata_i;
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (start) begin
      e0_q  <= in_i.exponent_0;
      e1_q  <= in_i.exponent_1;
      e2_q  <= in_i.exponent_2;
      e3_q  <= in_i.exponent_3;
      e4_q  <= in_i.exponent_4;
      e5_q  <= in_i.exponent_5;
      deg_q <= in_i.degree;
    end
  end

  // checks and partial degrees
  assign sum = SumW'(e0_q) + SumW'(e1_q) + SumW'(e2_q) + SumW'(e3_q)
             + SumW'(e4_q) + SumW'(e5_q);
  assign m   = IdxW'(e4_q) + IdxW'(e5_q);
  assign lim = (max_degree_q < ExpW'(MAX_DEGREE)) ? max_degree_q : ExpW'(MAX_DEGREE);
  assign n4  = deg_q - m[ExpW-1:0];
  assign n3  = n4 - e3_q;
  assign n2  = n3 - e2_q;

  always_comb begin
    if (sum != SumW'(deg_q)) begin
      status_w = STATUS_SUM;
    end else if (!m[0]) begin
      status_w = STATUS_PARITY;
    end else if (deg_q > lim) begin
      status_w = STATUS_DEGREE;
    end else begin
      status_w = STATUS_OK;
    end
  end

  // loop flags
  assign idx_p1    = idx_q + IdxW'(1);
  assign d_minus_i = deg_q - idx_q[ExpW-1:0];

  always_comb begin
    flags.err       = (status_w != STATUS_OK);
    flags.idx_lt_m  = (idx_q < m);
    flags.idx_le_n4 = (idx_q <= IdxW'(n4));
    flags.idx_le_n3 = (idx_q <= IdxW'(n3));
    flags.out_busy  = out_valid_q && !out_o.ready;
  end

  // operand select
  always_comb begin
    case (act.sel_a)
      A_E5:     mul_a = IdxW'(e5_q);
      A_IDX_P1: mul_a = idx_p1;
      default:  mul_a = IdxW'(1);
    endcase
    case (act.sel_b)
      B_W4_N4:  mul_b = W4Tab[n4];
      B_W4_D_I: mul_b = W4Tab[d_minus_i];
      B_W3_I:   mul_b = W3Tab[idx_q[ExpW-1:0]];
      B_IDX_P1: mul_b = WeightW'(idx_p1);
      default:  mul_b = WeightW'(e1_q);
    endcase
  end

  // shared multiply-add
  assign prod = PlaceW'(mul_a) * PlaceW'(mul_b);

  always_comb begin
    acc_d = acc_q;
    if (start) begin
      acc_d = '0;
    end else if (act.acc_en) begin
      acc_d = acc_q + prod;
    end
  end

  // loop index
  always_comb begin
    case (act.idx_op)
      IDX_ONE:  idx_d = IdxW'(1);
      IDX_N3P1: idx_d = IdxW'(n3) + IdxW'(1);
      IDX_N2P1: idx_d = IdxW'(n2) + IdxW'(1);
      IDX_INC1: idx_d = idx_q + IdxW'(1);
      IDX_INC2: idx_d = idx_q + IdxW'(2);
      default:  idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    idx_q <= idx_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (act.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act.out_ld) begin
      place_q  <= acc_q;
      status_q <= status_w;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.place  = place_q;
  assign out_o.status = status_q;

`ifndef SYNTHESIS
  // flagged words carry a zero rank
  a_place_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != STATUS_OK)) |-> (out_o.place == '0))
    else $error("nonzero place with error status");

  // no second word while one is in flight
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !in_i.ready)
    else $error("input ready right after accept");

  // the output register is free when loaded
  a_load_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act.out_ld |-> !out_valid_q)
    else $error("result overwrites a pending word");

  // psi3 table index stays in range inside its loop
  a_w3_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act.acc_en && (act.sel_b == B_W3_I)) |-> !idx_q[IdxW-1])
    else $error("psi3 index out of range");
`endif

endmodule

`default_nettype wire

[bench/opmr_rank_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// opmr_rank_checker
// Watches both channels of the ranker and the max_degree port, predicts the
// place and status of every accepted word and compares each result word
// against the oldest prediction in order.
// ---------------------------------------------------------------------------
module opmr_rank_checker #(
  parameter int unsigned MaxDegree = opmr_pkg::MaxDegreeDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [opmr_pkg::ExpW-1:0] cfg_wdata_i,
  opmr_in_if                        word_in,
  opmr_out_if                       word_out,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);
  import opmr_pkg::*;

  typedef logic [5:0][ExpW-1:0] expo_t;

  typedef struct packed {
    logic [PlaceW-1:0] place;
    status_e           status;
  } rank_t;

  rank_t           expected_ranks [$];
  rank_t           want;
  logic [ExpW-1:0] degree_cap;

  // psi3(j) = C(j+2,2)
  function automatic int unsigned tri_weight(input int unsigned j);
    return (j + 1) * (j + 2) / 2;
  endfunction

  // psi4(j) = C(j+3,3)
  function automatic int unsigned tet_weight(input int unsigned j);
    return (j + 1) * (j + 2) * (j + 3) / 6;
  endfunction

  // place of the monomial among odd-parity monomials of its degree
  function automatic rank_t rank_of(input expo_t ex, input logic [ExpW-1:0] deg,
                                    input logic [ExpW-1:0] cap);
    rank_t       r;
    int unsigned total;
    int unsigned pair;
    int unsigned lim;
    int unsigned n4;
    int unsigned n3;
    int unsigned n2;
    int unsigned acc;
    total = 0;
    for (int k = 0; k < 6; k++) begin
      total += ex[k];
    end
    pair  = ex[4] + ex[5];
    lim   = (cap < MaxDegree) ? cap : MaxDegree;
    r.place = '0;
    // errors in priority order: sum, parity, degree
    if (total != deg) begin
      r.status = STATUS_SUM;
    end else if (pair[0] == 1'b0) begin
      r.status = STATUS_PARITY;
    end else if (deg > lim) begin
      r.status = STATUS_DEGREE;
    end else begin
      n4  = deg - pair;
      acc = ex[5] * tet_weight(n4);
      for (int unsigned i = 1; i < pair; i += 2) begin
        acc += (i + 1) * tet_weight(deg - i);
      end
      n3 = n4 - ex[3];
      for (int unsigned i = n3 + 1; i <= n4; i++) begin
        acc += tri_weight(i);
      end
      n2 = n3 - ex[2];
      for (int unsigned i = n2 + 1; i <= n3; i++) begin
        acc += i + 1;
      end
      acc += ex[1];
      r.place  = PlaceW'(acc);
      r.status = STATUS_OK;
    end
    return r;
  endfunction

  // result words are checked before this edge's input word is queued
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_cap = ExpW'(MaxDegreeDef);
      expected_ranks.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        degree_cap = cfg_wdata_i;
      end
      if (word_out.valid && word_out.ready) begin
        if (expected_ranks.size() == 0) begin
          $error("unexpected word: place %0d status %0d", word_out.place, word_out.status);
          fail_count_o++;
        end else begin
          want = expected_ranks.pop_front();
          if (word_out.place !== want.place) begin
            $error("place: expected %0d, actual %0d", want.place, word_out.place);
            fail_count_o++;
          end
          if (word_out.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, word_out.status);
            fail_count_o++;
          end
        end
      end
      if (word_in.valid && word_in.ready) begin
        expected_ranks.push_back(rank_of({word_in.exponent_5, word_in.exponent_4,
                                          word_in.exponent_3, word_in.exponent_2,
                                          word_in.exponent_1, word_in.exponent_0},
                                         word_in.degree, degree_cap));
      end
      pending_o = expected_ranks.size();
    end
  end

endmodule

[bench/odd_parity_monomial_rank_top_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// odd_parity_monomial_rank_top_test
// Sends directed corner words and then random phases of mostly well-formed
// odd-parity monomials under several max_degree settings and idle patterns;
// the checker beside the block predicts and compares every result word.
// ---------------------------------------------------------------------------
module odd_parity_monomial_rank_top_test;
  import opmr_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseWords  = 181;
  localparam int unsigned SettleTicks = 100;

  // max_degree per random phase, phase 0 in the lowest slot
  localparam logic [NumPhases-1:0][ExpW-1:0] PhaseCap =
    {6'd63, 6'd45, 6'd62, 6'd12, 6'd0, 6'd31, 6'd1, 6'd63};

  // exponent vector packed as {e5, e4, e3, e2, e1, e0}
  typedef logic [5:0][ExpW-1:0] expo_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [ExpW-1:0] cfg_wdata_i;
  logic [ExpW-1:0] cap_now;
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     cycle_count = 0;
  int unsigned     fail_count;
  int unsigned     pending;
  expo_t           ex;
  logic [ExpW-1:0] deg;
  int unsigned     pick;

  opmr_in_if  in_ch ();
  opmr_out_if out_ch ();

  odd_parity_monomial_rank_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  opmr_rank_checker rank_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .word_in      (in_ch),
    .word_out     (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL odd_parity_monomial_rank_top");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  // present one word, with random idle cycles ahead of it
  task automatic send_word(input expo_t e, input logic [ExpW-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.exponent_0 = e[0];
    in_ch.exponent_1 = e[1];
    in_ch.exponent_2 = e[2];
    in_ch.exponent_3 = e[3];
    in_ch.exponent_4 = e[4];
    in_ch.exponent_5 = e[5];
    in_ch.degree     = d;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // write max_degree once every result has come back
  task automatic set_cap(input logic [ExpW-1:0] v);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cap_now  = v;
  endtask

  // odd-parity monomial whose exponents sum to its degree
  function automatic void gen_ranked(input logic [ExpW-1:0] cap, output expo_t e,
                                     output logic [ExpW-1:0] d);
    int unsigned hi;
    int unsigned total;
    int unsigned pair;
    int unsigned rest;
    int unsigned part;
    int unsigned start;
    e  = '0;
    hi = (cap == 0) ? 1 : cap;
    // mostly within the current limit
    if ($urandom_range(9) < 8) begin
      total = $urandom_range(hi, 1);
    end else begin
      total = $urandom_range(63, 1);
    end
    pair = 2 * $urandom_range((total - 1) / 2) + 1;
    e[5] = ExpW'($urandom_range(pair));
    e[4] = ExpW'(pair - e[5]);
    rest = total - pair;
    // spread the rest over e0..e3 starting at a random slot
    start = $urandom_range(3);
    for (int k = 0; k < 3; k++) begin
      part = $urandom_range(rest);
      e[(start + k) % 4] = ExpW'(part);
      rest -= part;
    end
    e[(start + 3) % 4] = ExpW'(rest);
    d = ExpW'(total);
  endfunction

  // stimulus
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    cap_now     = ExpW'(MaxDegreeDef);
    idle_pct    = 0;
    stall_pct   = 0;
    out_ch.ready     = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.exponent_0 = '0;
    in_ch.exponent_1 = '0;
    in_ch.exponent_2 = '0;
    in_ch.exponent_3 = '0;
    in_ch.exponent_4 = '0;
    in_ch.exponent_5 = '0;
    in_ch.degree     = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed words at the reset limit
    send_word({6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 6'd0);     // degree zero
    send_word({6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 6'd1);
    send_word({6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0}, 6'd1);
    send_word({6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd62}, 6'd63);
    send_word({6'd63, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 6'd63);
    send_word({6'd0, 6'd63, 6'd0, 6'd0, 6'd0, 6'd0}, 6'd63);
    send_word({6'd1, 6'd0, 6'd0, 6'd0, 6'd62, 6'd0}, 6'd63);
    send_word({6'd0, 6'd1, 6'd0, 6'd62, 6'd0, 6'd0}, 6'd63);
    send_word({6'd1, 6'd0, 6'd62, 6'd0, 6'd0, 6'd0}, 6'd63);
    send_word({6'd32, 6'd31, 6'd0, 6'd0, 6'd0, 6'd0}, 6'd63);  // longest odd loop
    send_word({6'd8, 6'd7, 6'd6, 6'd5, 6'd4, 6'd3}, 6'd33);
    send_word({6'd2, 6'd3, 6'd10, 6'd10, 6'd10, 6'd10}, 6'd45);
    send_word({6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd5}, 6'd4);     // sum mismatch
    send_word({6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63}, 6'd63); // sum above 63
    send_word({6'd1, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0}, 6'd2);     // even parity
    send_word({6'd2, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 6'd3);     // sum and parity
    send_word({6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd63}, 6'd63);

    // low limit: boundary and priority of parity over degree
    set_cap(6'd10);
    send_word({6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd9}, 6'd10);
    send_word({6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd10}, 6'd11);
    send_word({6'd0, 6'd2, 6'd0, 6'd0, 6'd0, 6'd9}, 6'd11);
    send_word({6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd62}, 6'd63);

    // zero limit flags every degree above zero
    set_cap(6'd0);
    send_word({6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 6'd1);
    send_word({6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 6'd0);

    // random phases
    for (int p = 0; p < NumPhases; p++) begin
      set_cap(PhaseCap[p]);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 55;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 55;
        end
        default: begin
          idle_pct  = 10;
          stall_pct = 10;
        end
      endcase
      for (int n = 0; n < PhaseWords; n++) begin
        gen_ranked(cap_now, ex, deg);
        pick = $urandom_range(99);
        if (pick >= 85) begin
          // noise
          ex  = expo_t'({$urandom(), $urandom()});
          deg = ExpW'($urandom());
        end else if (pick >= 78) begin
          // claimed degree off by one
          deg = $urandom_range(1) ? deg + 6'd1 : deg - 6'd1;
        end else if (pick >= 70) begin
          // shift one unit out of the pair to make its sum even
          if (ex[4] != 0) begin
            ex[4] = ex[4] - 6'd1;
          end else begin
            ex[5] = ex[5] - 6'd1;
          end
          ex[0] = ex[0] + 6'd1;
        end
        send_word(ex, deg);
      end
    end

    // drain and settle
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS odd_parity_monomial_rank_top");
    end else begin
      $display("FAIL odd_parity_monomial_rank_top");
    end
    $finish;
  end

endmodule
